// ===== rtl/core/cfar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfar_pkg: shared types and constants of the cell-averaging cfar detector
// fixed port widths, threshold reset value and the verdict side-band struct
// ----------------------------------------------------------------------------
package cfar_pkg;

  // fixed widths of the item fields and the threshold register
  localparam int unsigned SampleInW  = 16;
  localparam int unsigned ThrW       = 16;
  localparam int unsigned BinIndexW  = 12;

  // threshold multiplier after reset, 30.0 in unsigned q8.8
  localparam logic [ThrW-1:0] ThrReset = 16'd7680;

  // side-band of one verdict item
  typedef struct packed {
    logic [BinIndexW-1:0] bin_index;
    logic                 last;
  } meta_t;

endpackage

// ===== rtl/core/ca_cfar_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ca_cfar_detector_top: cell-averaging cfar detector
// throughput: one sample per cycle; the input stalls only while the hand-off,
// multiply and output registers all hold verdicts and the output is stalled
// reset: delay line, window sums and bin counter clear; threshold is 30.0
// the delay line is a row of cells, the test runs in a hand-off register,
// a multiply stage and the compare into the output register
// ----------------------------------------------------------------------------
module ca_cfar_detector_top #(
  parameter int unsigned WINDOW_CELLS = 16,
  parameter int unsigned GUARD_CELLS  = 3,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned MAX_BINS     = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfar_pkg::ThrW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cfar_pkg::SampleInW-1:0]      sample_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cfar_pkg::BinIndexW-1:0]      bin_index_o,
  output logic                                detected_o,
  output logic                                last_of_pulse_o
);

  localparam int unsigned LineLen  = 2 * WINDOW_CELLS + 2 * GUARD_CELLS + 1;
  localparam int unsigned FullIdx  = 2 * WINDOW_CELLS + 2 * GUARD_CELLS;
  localparam int unsigned CutPos   = WINDOW_CELLS + GUARD_CELLS;
  localparam int unsigned SumW     = SAMPLE_WIDTH + $clog2(WINDOW_CELLS + 1);
  localparam int unsigned TotW     = SAMPLE_WIDTH + $clog2(2 * WINDOW_CELLS + 1);
  localparam int unsigned CntW     = $clog2(MAX_BINS);
  localparam int unsigned CutScale = 2 * WINDOW_CELLS * 256;
  localparam int unsigned IdxW     = cfar_pkg::BinIndexW;

  logic [cfar_pkg::ThrW-1:0] thr_q;
  logic [SAMPLE_WIDTH-1:0]   samp;
  logic [SAMPLE_WIDTH-1:0]   line [LineLen];
  logic [SumW-1:0]           left_q, left_d, right_q, right_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      in_acc, produce;
  logic [IdxW-1:0]           idx_off;

  logic                      p1_v_q, p1_v_d;
  logic [SAMPLE_WIDTH-1:0]   p1_cut_q, p1_cut_d;
  logic [TotW-1:0]           p1_tot_q, p1_tot_d;
  cfar_pkg::meta_t           p1_meta_q, p1_meta_d;
  logic                      eval_ready;
  cfar_pkg::meta_t           out_meta;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cfar_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // sample at the internal width
  if (SAMPLE_WIDTH <= cfar_pkg::SampleInW) begin : g_samp_cut
    assign samp = sample_i[SAMPLE_WIDTH-1:0];
  end else begin : g_samp_ext
    assign samp = SAMPLE_WIDTH'(sample_i);
  end

  // input handshake
  assign in_stall_o = p1_v_q && !eval_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // delay line, newest sample in cell 0
  for (genvar i = 0; i < LineLen; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = samp;
    end else begin : g_body
      assign cell_in = line[i-1];
    end
    cfar_cell #(
      .DataW (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .clear_i (last_sample_i),
      .data_i  (cell_in),
      .data_o  (line[i])
    );
  end

  // running window sums and bin counter
  always_comb begin
    right_d = right_q + SumW'(samp) - SumW'(line[WINDOW_CELLS-1]);
    left_d  = left_q + SumW'(line[WINDOW_CELLS + 2 * GUARD_CELLS])
              - SumW'(line[LineLen-1]);
    cnt_d   = (cnt_q < CntW'(MAX_BINS - 1)) ? cnt_q + CntW'(1) : cnt_q;
    produce = 32'(cnt_q) >= FullIdx;
    idx_off = IdxW'(cnt_q) - IdxW'(CutPos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      cnt_q   <= '0;
    end else if (in_acc) begin
      if (last_sample_i) begin
        left_q  <= '0;
        right_q <= '0;
        cnt_q   <= '0;
      end else begin
        left_q  <= left_d;
        right_q <= right_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // hand the cell under test and background to the test stages
  always_comb begin
    p1_v_d    = p1_v_q;
    p1_cut_d  = p1_cut_q;
    p1_tot_d  = p1_tot_q;
    p1_meta_d = p1_meta_q;
    if (in_acc) begin
      p1_v_d              = produce;
      p1_cut_d            = line[CutPos-1];
      p1_tot_d            = TotW'(left_d) + TotW'(right_d);
      p1_meta_d.bin_index = idx_off;
      p1_meta_d.last      = last_sample_i;
    end else if (eval_ready) begin
      p1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= p1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_cut_q  <= p1_cut_d;
    p1_tot_q  <= p1_tot_d;
    p1_meta_q <= p1_meta_d;
  end

  // threshold test and output register
  cfar_eval #(
    .SampleW  (SAMPLE_WIDTH),
    .TotW     (TotW),
    .CutScale (CutScale)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .in_valid_i  (p1_v_q),
    .in_ready_o  (eval_ready),
    .cut_i       (p1_cut_q),
    .tot_i       (p1_tot_q),
    .meta_i      (p1_meta_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .detected_o  (detected_o),
    .meta_o      (out_meta)
  );

  assign bin_index_o     = out_meta.bin_index;
  assign last_of_pulse_o = out_meta.last;

  // end of pulse leaves counter and sums clear
  a_pulse_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_sample_i |=> cnt_q == '0 && left_q == '0 && right_q == '0)
    else $error("state not cleared after last item of pulse");

  // an item with full windows always reaches the test stage
  a_verdict_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && produce |=> p1_v_q)
    else $error("verdict item lost at test stage");

  // no verdict item while windows are still filling
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !produce && eval_ready |=> !p1_v_q)
    else $error("verdict item before windows are full");

endmodule

// ===== rtl/core/cfar_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfar_cell: one range-bin cell of the delay line
// holds one sample, takes its left neighbor's sample on each accepted item
// and clears at the end of a pulse
// ----------------------------------------------------------------------------
module cfar_cell #(
  parameter int unsigned DataW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  logic [DataW-1:0] data_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q, data_d;

  // shift in the neighbor's sample, or clear after the last item of a pulse
  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = clear_i ? '0 : data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/cfar_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfar_eval: threshold test of the cell under test
// multiply stage (scaled cell and scaled background), then compare into
// the output register; each stage moves when the one after it has room
// ----------------------------------------------------------------------------
module cfar_eval #(
  parameter int unsigned SampleW  = 16,
  parameter int unsigned TotW     = 22,
  parameter int unsigned CutScale = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cfar_pkg::ThrW-1:0]     thr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SampleW-1:0]            cut_i,
  input  logic [TotW-1:0]               tot_i,
  input  cfar_pkg::meta_t               meta_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          detected_o,
  output cfar_pkg::meta_t               meta_o
);

  localparam int unsigned LhsW = SampleW + $clog2(CutScale + 1);
  localparam int unsigned RhsW = cfar_pkg::ThrW + TotW;
  localparam int unsigned CmpW = (LhsW > RhsW) ? LhsW : RhsW;

  logic            mul_v_q, mul_v_d;
  logic [LhsW-1:0] lhs_q, lhs_d;
  logic [RhsW-1:0] rhs_q, rhs_d;
  cfar_pkg::meta_t mul_meta_q, mul_meta_d;

  logic            out_v_q, out_v_d;
  logic            det_q, det_d;
  cfar_pkg::meta_t out_meta_q, out_meta_d;

  logic out_free, mul_adv;

  // stage advance
  assign out_free   = !out_v_q || !out_stall_i;
  assign mul_adv    = !mul_v_q || out_free;
  assign in_ready_o = mul_adv;

  // multiply stage
  always_comb begin
    mul_v_d    = mul_v_q;
    lhs_d      = lhs_q;
    rhs_d      = rhs_q;
    mul_meta_d = mul_meta_q;
    if (mul_adv) begin
      mul_v_d    = in_valid_i;
      lhs_d      = LhsW'(cut_i) * LhsW'(CutScale);
      rhs_d      = RhsW'(thr_i) * RhsW'(tot_i);
      mul_meta_d = meta_i;
    end
  end

  // compare into the output register
  always_comb begin
    out_v_d    = out_v_q;
    det_d      = det_q;
    out_meta_d = out_meta_q;
    if (out_free) begin
      out_v_d    = mul_v_q;
      det_d      = CmpW'(lhs_q) > CmpW'(rhs_q);
      out_meta_d = mul_meta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      mul_v_q <= mul_v_d;
      out_v_q <= out_v_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
    mul_meta_q <= mul_meta_d;
    det_q      <= det_d;
    out_meta_q <= out_meta_d;
  end

  assign out_valid_o = out_v_q;
  assign detected_o  = det_q;
  assign meta_o      = out_meta_q;

endmodule
